### rtl/handshake_and_envelope_deframer_defines.svh
// Assertion macros for the handshake and envelope deframer.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef HANDSHAKE_AND_ENVELOPE_DEFRAMER_DEFINES_SVH
`define HANDSHAKE_AND_ENVELOPE_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define HED_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("deframer check failed");
// check that also holds while reset is high
`define HED_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("deframer reset check failed");
`else
`define HED_ASSERT(label, prop)
`define HED_ASSERT_RST(label, prop)
`endif

`endif

### rtl/hed_pkg.sv
// Shared types and constants of the handshake and envelope deframer.
// No dependencies.
`default_nettype none

package hed_pkg;

   localparam int unsigned ByteW      = 8;
   localparam int unsigned HdrBytes   = 6;
   localparam int unsigned HdrCntW    = 3;
   localparam int unsigned WordW      = HdrBytes * ByteW;
   localparam int unsigned TypeW      = 16;
   localparam int unsigned LenW       = 32;
   localparam int unsigned MagicW     = 32;
   localparam int unsigned VersionW   = 16;
   localparam int unsigned KindW      = 2;
   localparam int unsigned ErrW       = 2;
   localparam int unsigned CsrIdxW    = 2;
   localparam int unsigned CsrDataW   = 32;
   localparam int unsigned RspDataW   = 64;
   localparam int unsigned QueueDepth = 4;
   localparam logic [LenW-1:0] MaxPayloadReset = 32'd16777216;

   typedef enum logic [KindW-1:0] {
      KIND_HELLO  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_DATA   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [ErrW-1:0] {
      ERR_MAGIC   = 2'd0,
      ERR_VERSION = 2'd1,
      ERR_LENGTH  = 2'd2
   } err_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_MAGIC       = 2'd0,
      CSR_VERSION     = 2'd1,
      CSR_MAX_PAYLOAD = 2'd2
   } csr_idx_type;

   typedef struct packed {
      kind_type               kind;
      err_type                err;
      logic                   last;
      logic [WordW-1:0]       word;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

`default_nettype wire

### rtl/hed_front.sv
// Front end: register file, hello and envelope header gathering, classification.
// Depends on hed_pkg and the deframer assertion macros.
`default_nettype none
`include "handshake_and_envelope_deframer_defines.svh"

module hed_front
   import hed_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteW-1:0]     req_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wdata,
   input  wire logic                 queue_full,
   output push_type                  push
);

   typedef enum logic [1:0] {
      PH_HELLO   = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_HALT    = 2'd3
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [HdrCntW-1:0]    count_ff, count_in;
   logic [WordW-1:0]      hdr_ff, hdr_in;
   logic [LenW-1:0]       left_ff, left_in;
   logic [MagicW-1:0]     magic_ff;
   logic [VersionW-1:0]   version_ff;
   logic [LenW-1:0]       max_ff;

   logic                  accept;
   logic                  hdr_done;
   logic [WordW-1:0]      full_word;
   logic [LenW-1:0]       env_len;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign full_word  = {req_tdata, hdr_ff[WordW-1:ByteW]};
   assign hdr_done   = (count_ff == HdrCntW'(HdrBytes - 1));
   assign env_len    = full_word[TypeW +: LenW];

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
         max_ff     <= MaxPayloadReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:       magic_ff   <= csr_wdata[MagicW-1:0];
            CSR_VERSION:     version_ff <= csr_wdata[VersionW-1:0];
            CSR_MAX_PAYLOAD: max_ff     <= csr_wdata[LenW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      hdr_in   = hdr_ff;
      left_in  = left_ff;
      push     = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HELLO, PH_HEADER: begin
               hdr_in = full_word;
               if (!hdr_done) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  count_in   = '0;
                  push.valid = 1'b1;
                  push.entry.word = full_word;
                  if (phase_ff == PH_HELLO) begin
                     priority if (full_word[MagicW-1:0] != magic_ff) begin
                        phase_in         = PH_HALT;
                        push.entry.kind  = KIND_ERROR;
                        push.entry.err   = ERR_MAGIC;
                     end else if (full_word[MagicW +: VersionW] != version_ff) begin
                        phase_in         = PH_HALT;
                        push.entry.kind  = KIND_ERROR;
                        push.entry.err   = ERR_VERSION;
                     end else begin
                        phase_in         = PH_HEADER;
                        push.entry.kind  = KIND_HELLO;
                     end
                  end else begin
                     priority if (env_len > max_ff) begin
                        phase_in         = PH_HALT;
                        push.entry.kind  = KIND_ERROR;
                        push.entry.err   = ERR_LENGTH;
                     end else if (env_len == '0) begin
                        push.entry.kind  = KIND_HEADER;
                        push.entry.last  = 1'b1;
                     end else begin
                        phase_in         = PH_PAYLOAD;
                        left_in          = env_len;
                        push.entry.kind  = KIND_HEADER;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               push.valid      = 1'b1;
               push.entry.kind = KIND_DATA;
               push.entry.word = WordW'(req_tdata);
               left_in         = left_ff - 1'b1;
               if (left_ff <= LenW'(1)) begin
                  push.entry.last = 1'b1;
                  left_in         = '0;
                  phase_in        = PH_HEADER;
                  count_in        = '0;
               end
            end
            PH_HALT: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HELLO;
         count_ff <= '0;
         hdr_ff   <= '0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         hdr_ff   <= hdr_in;
         left_ff  <= left_in;
      end
   end

   `HED_ASSERT(a_halt_silent, phase_ff == PH_HALT |-> !push.valid)
   `HED_ASSERT(a_push_room, push.valid |-> !queue_full)
   `HED_ASSERT(a_count_bound, count_ff <= HdrCntW'(HdrBytes - 1))

endmodule

`default_nettype wire

### rtl/hed_queue.sv
// Short result queue between the front end and the output stage.
// Depends on hed_pkg and the deframer assertion macros.
`default_nettype none
`include "handshake_and_envelope_deframer_defines.svh"

module hed_queue
   import hed_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire push_type   push,
   output logic            full,
   output logic            head_valid,
   output entry_type       head,
   input  wire logic       pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `HED_ASSERT_RST(a_reset_empty, reset |=> count_ff == '0)
   `HED_ASSERT(a_count_range, count_ff <= CNT_W'(DEPTH))
   `HED_ASSERT(a_fill_up, do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
   `HED_ASSERT(a_no_underflow, pop |-> head_valid)

endmodule

`default_nettype wire

### rtl/hed_back.sv
// Output stage: pops queued results and formats the response register.
// Depends on hed_pkg.
`default_nettype none

module hed_back
   import hed_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire entry_type            head,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RspDataW-1:0]       rsp_tdata,
   output logic [KindW-1:0]          rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int unsigned PAD_W = RspDataW - (TypeW + LenW + ByteW + ErrW);

   logic                   valid_ff;
   logic [RspDataW-1:0]    data_ff, data_in;
   logic [KindW-1:0]       user_ff;
   logic                   last_ff;

   logic [TypeW-1:0]       f_type;
   logic [LenW-1:0]        f_len;
   logic [ByteW-1:0]       f_data;
   logic [ErrW-1:0]        f_err;

   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      f_type = '0;
      f_len  = '0;
      f_data = '0;
      f_err  = '0;
      unique case (head.kind)
         KIND_HEADER: begin
            f_type = head.word[TypeW-1:0];
            f_len  = head.word[TypeW +: LenW];
         end
         KIND_DATA:  f_data = head.word[ByteW-1:0];
         KIND_ERROR: f_err  = head.err;
         default: begin
         end
      endcase
      data_in = {PAD_W'(0), f_err, f_data, f_len, f_type};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
         user_ff <= head.kind;
         last_ff <= head.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

### rtl/handshake_and_envelope_deframer.sv
// Handshake and envelope deframer: peer hello check and length-prefixed framing.
// Use: feed received link bytes on req_* (one byte per request); results appear
// on rsp_* with kind in rsp_tuser: hello accepted, message header, payload byte
// or error. rsp_tlast marks the final payload byte, or a header with no payload.
// Registers are written on csr_* (index 0 magic, 1 version, 2 max payload); write
// them only while the block is idle, as the block itself does not enforce this.
// Throughput: one byte per cycle, held by the front end taking a byte every
// cycle the result queue has room and the output register draining one result
// per cycle while rsp_tready is high.
// Path: a result is written into the queue as its byte is taken, then loaded into
// the output register; header bytes one to five give no result.
// Reset: synchronous; registers return to magic 0, version 0, max payload 2**24,
// and the block waits for a new hello. After an error bytes are taken and
// dropped until reset.
// Stall: while rsp_tready is low the output register holds; the queue absorbs
// up to QUEUE_DEPTH results, then req_tready drops.
// Depends on hed_pkg, hed_front, hed_queue and hed_back.
`default_nettype none

module handshake_and_envelope_deframer
   import hed_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteW-1:0]     req_tdata,    // [7:0] in_byte
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [15:0] msg_type, [47:16] msg_length, [55:48] data, [57:56] error_code
   output logic [RspDataW-1:0]       rsp_tdata,
   output logic [KindW-1:0]          rsp_tuser,    // [1:0] kind
   output logic                      rsp_tlast,
   input  wire logic                 csr_we,
   input  wire logic [CsrIdxW-1:0]   csr_index,
   input  wire logic [CsrDataW-1:0]  csr_wdata
);

   push_type    push;
   logic        queue_full;
   logic        head_valid;
   entry_type   head;
   logic        pop;

   hed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push       (push)
   );

   hed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   hed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for handshake_and_envelope_deframer: peer hello, envelopes and payload.
// Randomised bytes and idling on both streams; results are predicted and checked in order.
// Depends on hed_pkg and the deframer RTL.

module testbench;
   import hed_pkg::*;

   localparam logic [CsrIdxW-1:0] CSR_SPARE = 2'd3;
   localparam err_type NO_ERROR = ERR_MAGIC;   // error field reads zero outside error results
   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_BYTES = 160;
   localparam int LEN_CAP = 16;

   typedef enum logic [1:0] {
      STAGE_HELLO,
      STAGE_HEADER,
      STAGE_PAYLOAD,
      STAGE_HALTED
   } stage_type;

   typedef struct packed {
      kind_type          kind;
      logic [TypeW-1:0]  msg_type;
      logic [LenW-1:0]   msg_length;
      logic [ByteW-1:0]  data;
      logic              last;
      err_type           err;
   } result_type;

   class envelope_ledger;
      logic [MagicW-1:0]   magic;
      logic [VersionW-1:0] version;
      logic [LenW-1:0]     max_len;
      stage_type           stage;
      int                  count;
      logic [WordW-1:0]    gathered;
      logic [LenW-1:0]     left;
      result_type          awaited[$];
      int                  failures;

      function new();
         magic    = '0;
         version  = '0;
         max_len  = MaxPayloadReset;
         stage    = STAGE_HELLO;
         count    = 0;
         gathered = '0;
         left     = '0;
         failures = 0;
      endfunction

      function void write_register(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] value);
         case (index)
            CSR_MAGIC:       magic = value;
            CSR_VERSION:     version = value[VersionW-1:0];
            CSR_MAX_PAYLOAD: max_len = value;
            default: ;
         endcase
      endfunction

      function void await_result(kind_type kind, logic [TypeW-1:0] mtype,
                                 logic [LenW-1:0] len, logic [ByteW-1:0] data,
                                 logic last, err_type err);
         result_type r;
         r = '{kind, mtype, len, data, last, err};
         awaited.insert(awaited.size(), r);
      endfunction

      function void take_byte(logic [ByteW-1:0] b);
         logic [LenW-1:0] len;
         case (stage)
            STAGE_HELLO, STAGE_HEADER: begin
               gathered[ByteW*count +: ByteW] = b;
               count++;
               if (count == HdrBytes) begin
                  count = 0;
                  len = gathered[WordW-1:TypeW];
                  if (stage == STAGE_HELLO) begin
                     if (gathered[MagicW-1:0] != magic) begin
                        stage = STAGE_HALTED;
                        await_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_MAGIC);
                     end else if (gathered[WordW-1:MagicW] != version) begin
                        stage = STAGE_HALTED;
                        await_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_VERSION);
                     end else begin
                        stage = STAGE_HEADER;
                        await_result(KIND_HELLO, '0, '0, '0, 1'b0, NO_ERROR);
                     end
                  end else if (len > max_len) begin
                     stage = STAGE_HALTED;
                     await_result(KIND_ERROR, '0, '0, '0, 1'b0, ERR_LENGTH);
                  end else if (len == '0) begin
                     await_result(KIND_HEADER, gathered[TypeW-1:0], '0, '0, 1'b1, NO_ERROR);
                  end else begin
                     left  = len;
                     stage = STAGE_PAYLOAD;
                     await_result(KIND_HEADER, gathered[TypeW-1:0], len, '0, 1'b0, NO_ERROR);
                  end
                  gathered = '0;
               end
            end
            STAGE_PAYLOAD: begin
               if (left <= 1) begin
                  left  = '0;
                  stage = STAGE_HEADER;
                  await_result(KIND_DATA, '0, '0, b, 1'b1, NO_ERROR);
               end else begin
                  left--;
                  await_result(KIND_DATA, '0, '0, b, 1'b0, NO_ERROR);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_field(string name, logic [LenW-1:0] want, logic [LenW-1:0] got);
         if (want !== got) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void match_result(kind_type kind, logic [RspDataW-1:0] tdata, logic last);
         result_type want;
         if (awaited.size() == 0) begin
            $display("%0t unexpected result: expected none, actual kind %0d tdata %h last %b",
                     $time, kind, tdata, last);
            failures++;
            return;
         end
         want = awaited.pop_front();
         check_field("kind", want.kind, kind);
         check_field("msg_type", want.msg_type, tdata[15:0]);
         check_field("msg_length", want.msg_length, tdata[47:16]);
         check_field("data", want.data, tdata[55:48]);
         check_field("last", want.last, last);
         check_field("error_code", want.err, tdata[57:56]);
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ByteW-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [KindW-1:0]    rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;
   envelope_ledger ledger = new();

   handshake_and_envelope_deframer u_dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         if (rsp_tvalid && rsp_tready)
            ledger.match_result(kind_type'(rsp_tuser), rsp_tdata, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_byte(logic [ByteW-1:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.take_byte(b);
   endtask

   task automatic send_word(logic [WordW-1:0] w);
      for (int i = 0; i < HdrBytes; i++) send_byte(w[ByteW*i +: ByteW]);
   endtask

   task automatic send_envelope(logic [TypeW-1:0] mtype, logic [LenW-1:0] len);
      send_word({len, mtype});
      repeat (len) send_byte($urandom_range(255));
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] index, logic [CsrDataW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      ledger.write_register(index, value);
   endtask

   // hold the sender until every request has been answered and the pipeline is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_traffic(int budget);
      int sent;
      logic [LenW-1:0] cap;
      logic [LenW-1:0] len;
      sent = 0;
      cap = (ledger.max_len > LEN_CAP) ? LEN_CAP : ledger.max_len;
      while (sent < budget) begin
         len = ($urandom_range(7) == 0) ? cap : $urandom_range(cap);
         send_envelope($urandom_range(16'hFFFF), len);
         sent += HdrBytes + len;
      end
   endtask

   initial begin
      logic [LenW-1:0]  over;
      logic [TypeW-1:0] mtype;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_MAGIC, $urandom);
      csr_write(CSR_VERSION, $urandom_range(16'hFFFF));
      csr_write(CSR_MAX_PAYLOAD, 3);
      csr_we <= 1'b0;

      send_word({ledger.version, ledger.magic});
      send_envelope(16'hFFFF, 0);
      send_word({32'd2, 16'h0000});
      send_byte(8'h00);
      send_byte(8'hFF);
      send_envelope($urandom_range(16'hFFFF), 3);

      for (int p = 0; p < 3; p++) begin
         settle();
         case (p)
            0: begin
               send_idle = 23;
               recv_idle = 82;
               csr_write(CSR_MAX_PAYLOAD, '1);
               csr_write(CSR_MAGIC, '0);
               csr_write(CSR_VERSION, 16'hFFFF);
            end
            1: begin
               send_idle = 82;
               recv_idle = 23;
               csr_write(CSR_MAX_PAYLOAD, '0);
               csr_write(CSR_MAGIC, '1);
               csr_write(CSR_VERSION, '0);
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               csr_write(CSR_MAX_PAYLOAD, $urandom_range(1, LEN_CAP));
               csr_write(CSR_SPARE, $urandom);
            end
         endcase
         csr_we <= 1'b0;
         random_traffic(PHASE_BYTES);
      end

      // length over the limit halts the block; later bytes are dropped
      over  = $urandom_range(32'hFFFF_FFFF, ledger.max_len + 1);
      mtype = $urandom_range(16'hFFFF);
      send_word({over, mtype});
      repeat (10) send_byte($urandom_range(255));

      req_tvalid <= 1'b0;
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ledger.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/hed_pkg.sv
rtl/hed_front.sv
rtl/hed_queue.sv
rtl/hed_back.sv
rtl/handshake_and_envelope_deframer.sv
tb/sv/testbench.sv
